// ----- rtl/core/ogru_pkg.sv -----
// ----------------------------------------------------------------------------
// ogru_pkg
// Shared constants, codes and helpers for the occupancy grid ray update block.
// ----------------------------------------------------------------------------
`default_nettype none

package ogru_pkg;

   localparam int MAX_SIDE   = 256;
   localparam int COORD_W    = 8;
   localparam int ADDR_W     = 2 * COORD_W;
   localparam int GRID_DEPTH = MAX_SIDE * MAX_SIDE;
   localparam int REG_W      = 9;
   localparam int CELL_W     = 2;
   localparam int STATUS_W   = 3;
   localparam int ERR_W      = COORD_W + 3;

   localparam logic [REG_W-1:0]  SIDE_LIMIT = REG_W'(MAX_SIDE);
   localparam logic [ADDR_W-1:0] GRID_LAST  = ADDR_W'(GRID_DEPTH - 1);

   localparam logic [CELL_W-1:0] CELL_UNKNOWN  = 2'd0;
   localparam logic [CELL_W-1:0] CELL_FREE     = 2'd1;
   localparam logic [CELL_W-1:0] CELL_OCCUPIED = 2'd2;

   localparam logic [STATUS_W-1:0] STAT_RAY_OK    = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_START_OUT = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_END_OUT   = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_READ_OK   = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_READ_OUT  = 3'd4;

   localparam logic FUNC_RAY  = 1'b0;
   localparam logic FUNC_READ = 1'b1;

   localparam logic REG_MAP_WIDTH  = 1'b0;
   localparam logic REG_MAP_HEIGHT = 1'b1;

   typedef enum logic [5:0] {
      ST_CLEAR  = 6'b000001,
      ST_IDLE   = 6'b000010,
      ST_WALK   = 6'b000100,
      ST_HIT    = 6'b001000,
      ST_RDWAIT = 6'b010000,
      ST_RESP   = 6'b100000
   } state_type;

   function automatic logic cell_inside(input logic [COORD_W-1:0] x,
                                        input logic [COORD_W-1:0] y,
                                        input logic [REG_W-1:0]   w,
                                        input logic [REG_W-1:0]   h);
      logic [REG_W-1:0] xe;
      logic [REG_W-1:0] ye;
      xe = {1'b0, x};
      ye = {1'b0, y};
      return (xe < w) && (xe < SIDE_LIMIT) && (ye < h) && (ye < SIDE_LIMIT);
   endfunction

   // row * MAX_SIDE + column
   function automatic logic [ADDR_W-1:0] cell_addr(input logic [COORD_W-1:0] x,
                                                  input logic [COORD_W-1:0] y);
      return {y, x};
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/ogru_ram.sv -----
// ----------------------------------------------------------------------------
// ogru_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module ogru_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 65536
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/occupancy_grid_ray_update.sv -----
// ----------------------------------------------------------------------------
// occupancy_grid_ray_update
// Occupancy grid with Bresenham ray update and single-cell read.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake           Payload
// req_      in         valid / stall       func, start/end cell, max_range, read cell
// rsp_      out        valid / stall       status, cell_state
// csr_      in         valid / ready       index, wdata (map_width, map_height)
//
// After reset a clearing pass writes all 65536 cells unknown (one cell per
// cycle through the grid RAM write port); no item is taken then.
// A ray of n cells before its end cell makes one grid RAM read per cell; the
// free write, made only for a cell still unknown, follows its read in the next cycle.
// A rejected ray or a read outside goes straight to the response state; a read inside waits for the RAM data first.
// A stalled result sits in the output register; the next result waits for it.
// ----------------------------------------------------------------------------
`default_nettype none

module occupancy_grid_ray_update
   import ogru_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic                 req_func,
   input  wire logic [COORD_W-1:0]   req_start_x,
   input  wire logic [COORD_W-1:0]   req_start_y,
   input  wire logic [COORD_W-1:0]   req_end_x,
   input  wire logic [COORD_W-1:0]   req_end_y,
   input  wire logic                 req_max_range,
   input  wire logic [COORD_W-1:0]   req_read_x,
   input  wire logic [COORD_W-1:0]   req_read_y,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic      [STATUS_W-1:0]  rsp_status,
   output logic      [CELL_W-1:0]    rsp_cell_state,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic                 csr_index,
   input  wire logic [REG_W-1:0]     csr_wdata
);

   state_type                 state_ff, state_in;
   logic [REG_W-1:0]          map_width_ff, map_width_in;
   logic [REG_W-1:0]          map_height_ff, map_height_in;
   logic [ADDR_W-1:0]         clr_cnt_ff, clr_cnt_in;
   logic [COORD_W-1:0]        cx_ff, cx_in, cy_ff, cy_in;
   logic [COORD_W-1:0]        ex_ff, ex_in, ey_ff, ey_in;
   logic [COORD_W-1:0]        dx_ff, dx_in, dy_ff, dy_in;
   logic                      neg_x_ff, neg_x_in, neg_y_ff, neg_y_in;
   logic signed [ERR_W-1:0]   err_ff, err_in;
   logic                      hit_ff, hit_in;
   logic                      wr_pend_ff, wr_pend_in;
   logic [ADDR_W-1:0]         wr_addr_ff, wr_addr_in;
   logic [STATUS_W-1:0]       res_status_ff, res_status_in;
   logic [CELL_W-1:0]         res_cell_ff, res_cell_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]       rsp_status_ff, rsp_status_in;
   logic [CELL_W-1:0]         rsp_cell_ff, rsp_cell_in;

   logic                      ram_wr_en;
   logic [ADDR_W-1:0]         ram_wr_addr;
   logic [CELL_W-1:0]         ram_wr_data;
   logic                      ram_rd_en;
   logic [ADDR_W-1:0]         ram_rd_addr;
   logic [CELL_W-1:0]         ram_rd_data;

   logic signed [ERR_W:0]     e2;
   logic                      step_x, step_y;
   logic [COORD_W-1:0]        dx_new, dy_new;

   ogru_ram #(
      .WIDTH (CELL_W),
      .DEPTH (GRID_DEPTH)
   ) u_grid (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_stall      = (state_ff != ST_IDLE);
   assign csr_ready      = 1'b1;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_cell_state = rsp_cell_ff;

   // Bresenham step
   assign e2     = {err_ff, 1'b0};
   assign step_x = e2 > -$signed({{(ERR_W-COORD_W+1){1'b0}}, dy_ff});
   assign step_y = e2 <  $signed({{(ERR_W-COORD_W+1){1'b0}}, dx_ff});
   assign dx_new = (req_start_x > req_end_x) ? req_start_x - req_end_x
                                             : req_end_x - req_start_x;
   assign dy_new = (req_start_y > req_end_y) ? req_start_y - req_end_y
                                             : req_end_y - req_start_y;

   always_comb begin
      state_in      = state_ff;
      map_width_in  = map_width_ff;
      map_height_in = map_height_ff;
      clr_cnt_in    = clr_cnt_ff;
      cx_in         = cx_ff;
      cy_in         = cy_ff;
      ex_in         = ex_ff;
      ey_in         = ey_ff;
      dx_in         = dx_ff;
      dy_in         = dy_ff;
      neg_x_in      = neg_x_ff;
      neg_y_in      = neg_y_ff;
      err_in        = err_ff;
      hit_in        = hit_ff;
      wr_pend_in    = 1'b0;
      wr_addr_in    = wr_addr_ff;
      res_status_in = res_status_ff;
      res_cell_in   = res_cell_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_cell_in   = rsp_cell_ff;

      ram_rd_en   = 1'b0;
      ram_rd_addr = cell_addr(cx_ff, cy_ff);
      ram_wr_en   = wr_pend_ff && (ram_rd_data == CELL_UNKNOWN);
      ram_wr_addr = wr_addr_ff;
      ram_wr_data = CELL_FREE;

      if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_MAP_WIDTH:  map_width_in  = csr_wdata;
            REG_MAP_HEIGHT: map_height_in = csr_wdata;
            default: ;
         endcase
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_cnt_ff;
            ram_wr_data = CELL_UNKNOWN;
            clr_cnt_in  = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == GRID_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               res_cell_in = CELL_UNKNOWN;
               if (req_func == FUNC_READ) begin
                  if (cell_inside(req_read_x, req_read_y, map_width_ff, map_height_ff)) begin
                     ram_rd_en   = 1'b1;
                     ram_rd_addr = cell_addr(req_read_x, req_read_y);
                     state_in    = ST_RDWAIT;
                  end else begin
                     res_status_in = STAT_READ_OUT;
                     state_in      = ST_RESP;
                  end
               end else if (!cell_inside(req_start_x, req_start_y,
                                         map_width_ff, map_height_ff)) begin
                  res_status_in = STAT_START_OUT;
                  state_in      = ST_RESP;
               end else if (!cell_inside(req_end_x, req_end_y,
                                         map_width_ff, map_height_ff)) begin
                  res_status_in = STAT_END_OUT;
                  state_in      = ST_RESP;
               end else begin
                  res_status_in = STAT_RAY_OK;
                  cx_in         = req_start_x;
                  cy_in         = req_start_y;
                  ex_in         = req_end_x;
                  ey_in         = req_end_y;
                  dx_in         = dx_new;
                  dy_in         = dy_new;
                  neg_x_in      = !(req_start_x < req_end_x);
                  neg_y_in      = !(req_start_y < req_end_y);
                  err_in        = $signed({3'b000, dx_new}) - $signed({3'b000, dy_new});
                  hit_in        = !req_max_range;
                  state_in      = ST_WALK;
               end
            end
         end
         ST_WALK: begin
            if ((cx_ff == ex_ff) && (cy_ff == ey_ff)) begin
               state_in = ST_HIT;
            end else begin
               ram_rd_en  = 1'b1;
               wr_pend_in = 1'b1;
               wr_addr_in = cell_addr(cx_ff, cy_ff);
               err_in     = err_ff
                            - (step_x ? $signed({3'b000, dy_ff}) : '0)
                            + (step_y ? $signed({3'b000, dx_ff}) : '0);
               if (step_x) begin
                  cx_in = neg_x_ff ? cx_ff - 1'b1 : cx_ff + 1'b1;
               end
               if (step_y) begin
                  cy_in = neg_y_ff ? cy_ff - 1'b1 : cy_ff + 1'b1;
               end
            end
         end
         ST_HIT: begin
            if (hit_ff) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = cell_addr(ex_ff, ey_ff);
               ram_wr_data = CELL_OCCUPIED;
            end
            state_in = ST_RESP;
         end
         ST_RDWAIT: begin
            res_status_in = STAT_READ_OK;
            res_cell_in   = ram_rd_data;
            state_in      = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_cell_in   = res_cell_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         map_width_ff  <= SIDE_LIMIT;
         map_height_ff <= SIDE_LIMIT;
         clr_cnt_ff    <= '0;
         wr_pend_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         map_width_ff  <= map_width_in;
         map_height_ff <= map_height_in;
         clr_cnt_ff    <= clr_cnt_in;
         wr_pend_ff    <= wr_pend_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cx_ff         <= cx_in;
      cy_ff         <= cy_in;
      ex_ff         <= ex_in;
      ey_ff         <= ey_in;
      dx_ff         <= dx_in;
      dy_ff         <= dy_in;
      neg_x_ff      <= neg_x_in;
      neg_y_ff      <= neg_y_in;
      err_ff        <= err_in;
      hit_ff        <= hit_in;
      wr_addr_ff    <= wr_addr_in;
      res_status_ff <= res_status_in;
      res_cell_ff   <= res_cell_in;
      rsp_status_ff <= rsp_status_in;
      rsp_cell_ff   <= rsp_cell_in;
   end

   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !ram_wr_en)
      else $error("grid written while idle");

   a_walk_frees_only: assert property (@(posedge clock) disable iff (reset)
      (ram_wr_en && state_ff == ST_WALK) |-> (ram_wr_data == CELL_FREE))
      else $error("walk wrote a cell other than free");

   a_hit_after_drain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_HIT) |-> (!wr_pend_ff && $past(state_ff) == ST_WALK))
      else $error("end cell write overlaps a pending free write");

   a_resp_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RESP && !rsp_valid_ff) |=> rsp_valid_ff)
      else $error("pending result not presented");

endmodule

`default_nettype wire

// ----- tb/occupancy_grid_ray_update_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// occupancy_grid_ray_update_test
// Self-checking bench for the occupancy grid ray update block.
// Keeps a shadow grid and map size and walks every accepted ray the same way
// the block should. Every reply is compared with the oldest prediction.
// Stimulus starts with a directed set of rays and reads, then runs random
// phases over several map sizes with idle and stall patterns on both channels.
// ----------------------------------------------------------------------------

module occupancy_grid_ray_update_test
   import ogru_pkg::*;
;

   localparam int CYCLE_LIMIT  = 4_000_000;
   localparam int PHASE_ITEMS  = 125;
   localparam int NUM_PHASES   = 10;
   localparam int PRINT_LIMIT  = 200;

   typedef struct {
      logic               func;
      logic [COORD_W-1:0] start_x;
      logic [COORD_W-1:0] start_y;
      logic [COORD_W-1:0] end_x;
      logic [COORD_W-1:0] end_y;
      logic               max_range;
      logic [COORD_W-1:0] read_x;
      logic [COORD_W-1:0] read_y;
   } grid_item_type;

   typedef struct {
      logic [STATUS_W-1:0] status;
      logic [CELL_W-1:0]   cell_val;
      int                  seq;
   } grid_reply_type;

   class grid_scoreboard_type;
      logic [CELL_W-1:0] cells [GRID_DEPTH];
      logic [REG_W-1:0]  map_width;
      logic [REG_W-1:0]  map_height;
      grid_reply_type    replies[$];
      int                item_count;
      int                error_count;

      function new();
         foreach (cells[i]) cells[i] = CELL_UNKNOWN;
         map_width   = REG_W'(MAX_SIDE);
         map_height  = REG_W'(MAX_SIDE);
         item_count  = 0;
         error_count = 0;
      endfunction

      function void set_reg(logic idx, logic [REG_W-1:0] value);
         if (idx == REG_MAP_WIDTH) map_width = value;
         else map_height = value;
      endfunction

      function bit on_map(int x, int y);
         return x < int'(map_width) && x < MAX_SIDE && y < int'(map_height) && y < MAX_SIDE;
      endfunction

      function void cast_ray(int x0, int y0, int x1, int y1, bit no_hit);
         int dx, dy, sx, sy, err, e2, cx, cy;
         dx = (x1 > x0) ? x1 - x0 : x0 - x1;
         dy = (y1 > y0) ? y1 - y0 : y0 - y1;
         sx = (x0 < x1) ? 1 : -1;
         sy = (y0 < y1) ? 1 : -1;
         err = dx - dy;
         cx = x0;
         cy = y0;
         while (!(cx == x1 && cy == y1)) begin
            if (cells[cy * MAX_SIDE + cx] == CELL_UNKNOWN) cells[cy * MAX_SIDE + cx] = CELL_FREE;
            e2 = 2 * err;
            if (e2 > -dy) begin
               err -= dy;
               cx += sx;
            end
            if (e2 < dx) begin
               err += dx;
               cy += sy;
            end
         end
         if (!no_hit) cells[y1 * MAX_SIDE + x1] = CELL_OCCUPIED;
      endfunction

      function grid_reply_type predict_reply(grid_item_type it);
         grid_reply_type r;
         r.cell_val = CELL_UNKNOWN;
         r.seq      = item_count;
         if (it.func == FUNC_RAY) begin
            if (!on_map(int'(it.start_x), int'(it.start_y))) r.status = STAT_START_OUT;
            else if (!on_map(int'(it.end_x), int'(it.end_y))) r.status = STAT_END_OUT;
            else begin
               cast_ray(int'(it.start_x), int'(it.start_y), int'(it.end_x), int'(it.end_y),
                        it.max_range);
               r.status = STAT_RAY_OK;
            end
         end else if (on_map(int'(it.read_x), int'(it.read_y))) begin
            r.status   = STAT_READ_OK;
            r.cell_val = cells[int'(it.read_y) * MAX_SIDE + int'(it.read_x)];
         end else begin
            r.status = STAT_READ_OUT;
         end
         return r;
      endfunction

      function void note_item(grid_item_type it);
         replies.insert(replies.size(), predict_reply(it));
         item_count++;
      endfunction

      function int pending();
         return replies.size();
      endfunction

      task report(string msg);
         if (error_count < PRINT_LIMIT) $display("ERROR %0t: %s", $realtime, msg);
         error_count++;
      endtask

      task check_reply(logic [STATUS_W-1:0] status, logic [CELL_W-1:0] cell_val);
         grid_reply_type want;
         if (replies.size() == 0) begin
            report($sformatf("unexpected reply status %0d cell %0d", status, cell_val));
            return;
         end
         want = replies.pop_front();
         if (status !== want.status)
            report($sformatf("item %0d status %0d, want %0d", want.seq, status, want.status));
         if (cell_val !== want.cell_val)
            report($sformatf("item %0d cell %0d, want %0d", want.seq, cell_val,
                             want.cell_val));
      endtask
   endclass

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic                req_func;
   logic [COORD_W-1:0]  req_start_x;
   logic [COORD_W-1:0]  req_start_y;
   logic [COORD_W-1:0]  req_end_x;
   logic [COORD_W-1:0]  req_end_y;
   logic                req_max_range;
   logic [COORD_W-1:0]  req_read_x;
   logic [COORD_W-1:0]  req_read_y;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [STATUS_W-1:0] rsp_status;
   logic [CELL_W-1:0]   rsp_cell_state;
   logic                csr_valid;
   logic                csr_ready;
   logic                csr_index;
   logic [REG_W-1:0]    csr_wdata;

   grid_scoreboard_type sb;
   int cycle_count = 0;
   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   int last_x = 0;
   int last_y = 0;

   occupancy_grid_ray_update uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_func       (req_func),
      .req_start_x    (req_start_x),
      .req_start_y    (req_start_y),
      .req_end_x      (req_end_x),
      .req_end_y      (req_end_y),
      .req_max_range  (req_max_range),
      .req_read_x     (req_read_x),
      .req_read_y     (req_read_y),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_cell_state (rsp_cell_state),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // reply side
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         rsp_stall = (receiver_stall_pct != 0) && ($urandom_range(99) < receiver_stall_pct);
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) sb.check_reply(rsp_status, rsp_cell_state);
      end
   end

   function automatic grid_item_type any_item();
      grid_item_type it;
      it.func      = 1'($urandom_range(1));
      it.start_x   = COORD_W'($urandom_range(255));
      it.start_y   = COORD_W'($urandom_range(255));
      it.end_x     = COORD_W'($urandom_range(255));
      it.end_y     = COORD_W'($urandom_range(255));
      it.max_range = 1'($urandom_range(1));
      it.read_x    = COORD_W'($urandom_range(255));
      it.read_y    = COORD_W'($urandom_range(255));
      return it;
   endfunction

   function automatic grid_item_type ray_item(int sx, int sy, int ex, int ey, bit mr);
      grid_item_type it;
      it = any_item();
      it.func      = FUNC_RAY;
      it.start_x   = COORD_W'(sx);
      it.start_y   = COORD_W'(sy);
      it.end_x     = COORD_W'(ex);
      it.end_y     = COORD_W'(ey);
      it.max_range = mr;
      return it;
   endfunction

   function automatic grid_item_type read_item(int x, int y);
      grid_item_type it;
      it = any_item();
      it.func   = FUNC_READ;
      it.read_x = COORD_W'(x);
      it.read_y = COORD_W'(y);
      return it;
   endfunction

   function automatic int pick(int lim);
      return $urandom_range(lim - 1, 0);
   endfunction

   function automatic int near(int v, int lim, int span);
      int n;
      n = v + int'($urandom_range(2 * span)) - span;
      if (n > lim - 1) n = lim - 1;
      if (n < 0) n = 0;
      return n;
   endfunction

   // mostly rays and reads that land on the map, the rest anywhere
   function automatic grid_item_type random_item(int wl, int hl);
      grid_item_type it;
      bit fits;
      int roll;
      int sx, sy;
      fits = wl > 0 && hl > 0;
      roll = $urandom_range(99);
      if ($urandom_range(99) < 60) begin
         if (fits && roll < 85) begin
            sx = pick(wl);
            sy = pick(hl);
            if ($urandom_range(1))
               it = ray_item(sx, sy, near(sx, wl, 16), near(sy, hl, 16),
                             $urandom_range(99) < 25);
            else
               it = ray_item(sx, sy, pick(wl), pick(hl), $urandom_range(99) < 25);
         end else begin
            it = any_item();
            it.func = FUNC_RAY;
         end
         last_x = $urandom_range(1) ? int'(it.end_x) : int'(it.start_x);
         last_y = $urandom_range(1) ? int'(it.end_y) : int'(it.start_y);
      end else begin
         if (fits && roll < 50) it = read_item(near(last_x, wl, 2), near(last_y, hl, 2));
         else if (fits && roll < 85) it = read_item(pick(wl), pick(hl));
         else begin
            it = any_item();
            it.func = FUNC_READ;
         end
      end
      return it;
   endfunction

   task automatic send_item(input grid_item_type it);
      @(negedge clock);
      while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid     = 1'b1;
      req_func      = it.func;
      req_start_x   = it.start_x;
      req_start_y   = it.start_y;
      req_end_x     = it.end_x;
      req_end_y     = it.end_y;
      req_max_range = it.max_range;
      req_read_x    = it.read_x;
      req_read_y    = it.read_y;
      do @(posedge clock); while (req_stall);
      sb.note_item(it);
   endtask

   task automatic wait_grid_quiet();
      @(negedge clock);
      req_valid = 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic idx, input int value);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = REG_W'(value);
      do @(posedge clock); while (!csr_ready);
      sb.set_reg(idx, REG_W'(value));
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic set_map(input int w, input int h);
      wait_grid_quiet();
      write_reg(REG_MAP_WIDTH, w);
      write_reg(REG_MAP_HEIGHT, h);
   endtask

   initial begin
      int widths  [NUM_PHASES];
      int heights [NUM_PHASES];
      int wl, hl;

      widths  = '{256, 511, 16, 1, 200, 256, 0, 300, 64, 256};
      heights = '{256, 300, 12, 256, 1, 0, 256, 511, 40, 256};
      sb = new();
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_func      = FUNC_RAY;
      req_start_x   = '0;
      req_start_y   = '0;
      req_end_x     = '0;
      req_end_y     = '0;
      req_max_range = 1'b0;
      req_read_x    = '0;
      req_read_y    = '0;
      csr_valid     = 1'b0;
      csr_index     = REG_MAP_WIDTH;
      csr_wdata     = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // full map after reset: corners, diagonals, single-cell rays, overlaps
      send_item(read_item(0, 0));
      send_item(read_item(255, 255));
      send_item(ray_item(0, 0, 255, 255, 1'b0));
      send_item(read_item(128, 128));
      send_item(read_item(255, 255));
      send_item(ray_item(10, 10, 10, 10, 1'b0));
      send_item(read_item(10, 10));
      send_item(ray_item(20, 20, 20, 20, 1'b1));
      send_item(read_item(20, 20));
      send_item(ray_item(255, 0, 0, 255, 1'b1));
      send_item(ray_item(5, 10, 15, 10, 1'b0));
      send_item(read_item(10, 10));
      send_item(ray_item(0, 5, 0, 0, 1'b0));
      send_item(read_item(0, 0));
      send_item(ray_item(3, 200, 7, 0, 1'b0));
      send_item(ray_item(0, 100, 255, 103, 1'b1));

      // shrunken map: start, end and read outside
      set_map(20, 10);
      send_item(ray_item(30, 0, 0, 0, 1'b0));
      send_item(ray_item(30, 12, 40, 40, 1'b0));
      send_item(ray_item(0, 0, 0, 15, 1'b0));
      send_item(read_item(25, 5));
      send_item(read_item(19, 9));
      send_item(read_item(5, 10));

      // zero width: nothing on the map
      set_map(0, 10);
      send_item(read_item(0, 0));
      send_item(ray_item(0, 0, 0, 0, 1'b0));

      // oversized registers: whole 8-bit range on the map
      set_map(511, 300);
      send_item(read_item(255, 255));

      for (int p = 0; p < NUM_PHASES; p++) begin
         set_map(widths[p], heights[p]);
         case (p % 4)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 49; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 49; end
            default: begin sender_idle_pct = 23; receiver_stall_pct = 23; end
         endcase
         wl = (widths[p] < MAX_SIDE) ? widths[p] : MAX_SIDE;
         hl = (heights[p] < MAX_SIDE) ? heights[p] : MAX_SIDE;
         for (int i = 0; i < PHASE_ITEMS; i++) send_item(random_item(wl, hl));
      end

      wait_grid_quiet();
      repeat (20) @(posedge clock);
      if (sb.error_count == 0 && sb.pending() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
